[src/char_stack_insert_after_defines.svh]
// ----------------------------------------------------------------------------
// char_stack_insert_after_defines
// Assertion macros for the stack design.
// ----------------------------------------------------------------------------
`ifndef CHAR_STACK_INSERT_AFTER_DEFINES_SVH
`define CHAR_STACK_INSERT_AFTER_DEFINES_SVH

`ifndef SYNTHESIS

`define CSIA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CSIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CSIA_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define CSIA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[src/csia_pkg.sv]
// ----------------------------------------------------------------------------
// csia_pkg
// Types and constants of the byte stack with insert after first match.
// ----------------------------------------------------------------------------
package csia_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    cell_op_t          op;
    logic [DATA_W-1:0] item;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] top_data;
    logic [CNT_W-1:0]  fill;
  } cell_ctrl_t;

endpackage

[src/csia_in_if.sv]
// ----------------------------------------------------------------------------
// csia_in_if
// Command channel: valid/ready handshake with command, item and key.
// ----------------------------------------------------------------------------
interface csia_in_if
  import csia_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] item;
  logic [DATA_W-1:0] key;

  modport source (output valid, output cmd, output item, output key, input ready);
  modport sink   (input valid, input cmd, input item, input key, output ready);
endinterface

[src/csia_out_if.sv]
// ----------------------------------------------------------------------------
// csia_out_if
// Result channel: valid/ready handshake with status, data, last and count.
// ----------------------------------------------------------------------------
interface csia_out_if
  import csia_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [DATA_W-1:0]  data;
  logic               last;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output status, output data, output last,
                  output count, input ready);
  modport sink   (input valid, input status, input data, input last,
                  input count, output ready);
endinterface

[src/csia_cell.sv]
// ----------------------------------------------------------------------------
// csia_cell
// One stack slot: compares against the key, forwards the match chain and
// loads the new item, or shifts or rotates in the byte of the neighbor below.
// ----------------------------------------------------------------------------
module csia_cell
  import csia_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] lower,
  input  logic              seen_in,
  input  logic              first_in,
  output logic              seen_out,
  output logic              first_out,
  output logic [DATA_W-1:0] data
);

  logic [DATA_W-1:0] data_next;
  logic              valid;
  logic              hit;
  logic              at_fill;

  assign valid     = CNT_W'(idx) < ctrl.fill;
  assign at_fill   = CNT_W'(idx) == ctrl.fill;
  assign hit       = valid && (data == ctrl.key);
  assign seen_out  = seen_in || hit;
  assign first_out = hit && !seen_in;

  always_comb begin
    data_next = data;
    case (ctrl.op)
      OP_PUSH: begin
        if (at_fill) data_next = ctrl.item;
      end
      OP_INSERT: begin
        if (first_in) begin
          data_next = ctrl.item;
        end else if (seen_in && (valid || at_fill)) begin
          data_next = lower;
        end
      end
      OP_ROTATE: begin
        if (idx == '0) begin
          data_next = ctrl.top_data;
        end else if (valid) begin
          data_next = lower;
        end
      end
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[src/char_stack_insert_after.sv]
// ----------------------------------------------------------------------------
// char_stack_insert_after
// Bounded byte stack with push, insert after first key match, and dump.
// ----------------------------------------------------------------------------
// Push and insert give one result each; all cells compare the key and shift
// in parallel. A dump gives one result per cycle while the output is free,
// top first, as many results as the stack holds elements (one result when
// empty); the cell row rotates one step per result and is back in place at
// the end. Command 3 gives no result. One output register separates the
// channels; a new command is taken only when that register is empty or its
// result leaves in the same cycle, and never during a dump.
// ----------------------------------------------------------------------------
module char_stack_insert_after
  import csia_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  csia_in_if.sink    in_ch,
  csia_out_if.source out_ch
);

`include "char_stack_insert_after_defines.svh"

  state_t             state, state_next;
  logic [CNT_W-1:0]   fill, fill_next;
  logic [CNT_W-1:0]   left, left_next;
  logic               out_valid, out_valid_next;
  status_t            out_status, out_status_next;
  logic [DATA_W-1:0]  out_data, out_data_next;
  logic               out_last, out_last_next;
  logic [COUNT_W-1:0] out_count, out_count_next;

  cell_ctrl_t         ctrl;
  logic [DATA_W-1:0]  cell_data [DEPTH];
  logic               seen  [DEPTH+1];
  logic               first [DEPTH+1];
  logic [DATA_W-1:0]  top_data;
  logic               found;
  logic               full;
  logic               out_free;
  logic               acc;

  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign full        = fill == CNT_W'(DEPTH);
  assign found       = seen[DEPTH];
  assign top_data    = cell_data[IDX_W'(fill - 1'b1)];

  assign seen[0]  = 1'b0;
  assign first[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] lower;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_upper
      assign lower = cell_data[i-1];
    end
    csia_cell u_cell (
      .clk       (clk),
      .idx       (IDX_W'(i)),
      .ctrl      (ctrl),
      .lower     (lower),
      .seen_in   (seen[i]),
      .first_in  (first[i]),
      .seen_out  (seen[i+1]),
      .first_out (first[i+1]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    left_next       = left;
    out_valid_next  = out_valid && !out_ch.ready;
    out_status_next = out_status;
    out_data_next   = out_data;
    out_last_next   = out_last;
    out_count_next  = out_count;
    ctrl.op         = OP_HOLD;
    ctrl.item       = in_ch.item;
    ctrl.key        = in_ch.key;
    ctrl.top_data   = top_data;
    ctrl.fill       = fill;
    case (state)
      S_IDLE: begin
        if (acc) begin
          out_data_next  = '0;
          out_last_next  = 1'b1;
          out_count_next = COUNT_W'(fill);
          case (in_ch.cmd)
            CMD_PUSH: begin
              out_valid_next = 1'b1;
              if (full) begin
                out_status_next = ST_FULL;
              end else begin
                ctrl.op         = OP_PUSH;
                fill_next       = fill + 1'b1;
                out_status_next = ST_OK;
                out_count_next  = COUNT_W'(fill + 1'b1);
              end
            end
            CMD_INSERT: begin
              out_valid_next = 1'b1;
              if (full) begin
                out_status_next = ST_FULL;
              end else if (found) begin
                ctrl.op         = OP_INSERT;
                fill_next       = fill + 1'b1;
                out_status_next = ST_OK;
                out_count_next  = COUNT_W'(fill + 1'b1);
              end else begin
                out_status_next = ST_NOT_FOUND;
              end
            end
            CMD_DUMP: begin
              out_valid_next = 1'b1;
              if (fill == '0) begin
                out_status_next = ST_EMPTY;
              end else begin
                ctrl.op         = OP_ROTATE;
                out_status_next = ST_OK;
                out_data_next   = top_data;
                out_last_next   = fill == CNT_W'(1);
                left_next       = fill - 1'b1;
                if (fill != CNT_W'(1)) state_next = S_DUMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          ctrl.op         = OP_ROTATE;
          out_valid_next  = 1'b1;
          out_status_next = ST_OK;
          out_data_next   = top_data;
          out_last_next   = left == CNT_W'(1);
          out_count_next  = COUNT_W'(fill);
          left_next       = left - 1'b1;
          if (left == CNT_W'(1)) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      left      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      left      <= left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    out_status <= out_status_next;
    out_data   <= out_data_next;
    out_last   <= out_last_next;
    out_count  <= out_count_next;
  end

  assign out_ch.valid  = out_valid;
  assign out_ch.status = out_status;
  assign out_ch.data   = out_data;
  assign out_ch.last   = out_last;
  assign out_ch.count  = out_count;

  `CSIA_ASSERT_IMPLIES(a_fill_bound, clk, rst, 1'b1, fill <= CNT_W'(DEPTH))
  `CSIA_ASSERT_IMPLIES(a_dump_blocks, clk, rst, state == S_DUMP, !in_ch.ready)
  `CSIA_ASSERT_NEXT(a_push_grows, clk, rst, acc && in_ch.cmd == CMD_PUSH && !full, fill == $past(fill) + 1'b1)
  `CSIA_ASSERT_IMPLIES(a_error_last, clk, rst, out_valid && out_status != ST_OK, out_last)

endmodule
